// ===== rtl/core/rif_pkg.sv =====
package rif_pkg;

  localparam int unsigned Frac    = 16;
  localparam int unsigned NStages = 5;

  localparam logic signed [63:0] QMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] QMin = 64'shFFFF_FFFF_8000_0000;
  localparam logic [32:0]        WMax = 33'h0_7FFF_FFFF;

  typedef struct packed {
    logic [30:0]        rho_left;
    logic [30:0]        rho_right;
    logic signed [31:0] vel_left;
    logic signed [31:0] vel_right;
    logic [30:0]        pres_left;
    logic [30:0]        pres_right;
    logic signed [31:0] energy_left;
    logic signed [31:0] energy_right;
    logic [16:0]        humid_left;
    logic [16:0]        humid_right;
    logic [30:0]        sound_left;
    logic [30:0]        sound_right;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mass_out;
    logic signed [31:0] momentum_out;
    logic signed [31:0] energy_out;
    logic signed [31:0] vapor_out;
    logic [30:0]        wave_speed;
  } out_t;

  typedef struct packed {
    logic [NStages-1:0] load;
  } pipe_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > QMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < QMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

  function automatic logic signed [63:0] uext(input logic [30:0] v);
    return $signed({33'b0, v});
  endfunction

  function automatic logic signed [31:0] qmul_sat(input logic signed [63:0] p);
    return sat32(p >>> Frac);
  endfunction

  function automatic logic [30:0] wave(input logic signed [31:0] u, input logic [30:0] a);
    logic [31:0] mag;
    logic [32:0] sum;
    mag = u[31] ? (~u + 32'd1) : u;
    sum = {1'b0, mag} + {2'b0, a};
    return (sum > WMax) ? 31'h7FFF_FFFF : sum[30:0];
  endfunction

  function automatic logic signed [31:0] rusanov(input logic signed [31:0] fl,
                                                 input logic signed [31:0] fr,
                                                 input logic signed [46:0] diss);
    logic signed [63:0] avg;
    avg = (64'(fl) + 64'(fr)) >>> 1;
    return sat32(avg - 64'(diss));
  endfunction

endpackage

// ===== rtl/core/rif_stream_if.sv =====
interface rif_in_if;
  import rif_pkg::*;

  logic valid;
  logic ready;
  in_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface rif_out_if;
  import rif_pkg::*;

  logic valid;
  logic ready;
  out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/rif_pipe_ctrl.sv =====
module rif_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output rif_pkg::pipe_ctrl_t ctrl_o
);
  import rif_pkg::*;

  logic [NStages-1:0] valid_q, valid_d;
  logic [NStages:0]   rdy;
  logic [NStages-1:0] upstream;

  // A stage takes a new transaction when it is empty or its successor moves on.
  always_comb begin
    rdy[NStages] = out_ready_i;
    for (int k = NStages - 1; k >= 0; k--) begin
      rdy[k] = ~valid_q[k] | rdy[k+1];
    end
    upstream = {valid_q[NStages-2:0], in_valid_i};
    for (int k = 0; k < NStages; k++) begin
      ctrl_o.load[k] = rdy[k] & upstream[k];
      valid_d[k]     = rdy[k] ? upstream[k] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[NStages-1];
endmodule

// ===== rtl/core/rusanov_interface_flux_unit.sv =====
// One transaction per cycle while the output takes results; the five register stages each hold
// on a stall and take new data as soon as their successor moves on, so bubbles are squeezed out.
// Reset clears the stage valid bits only; no transaction is in flight after reset.
module rusanov_interface_flux_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  rif_in_if.sink   in_i,
  rif_out_if.source out_o
);
  import rif_pkg::*;

  pipe_ctrl_t ctrl;

  rif_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_ready_i(out_o.ready),
    .out_valid_o(out_o.valid),
    .ctrl_o     (ctrl)
  );

  // Stage one: first products, energy plus pressure, wave speeds.
  logic signed [63:0] s1_prl_q, s1_prr_q;
  logic [47:0]        s1_phl_q, s1_phr_q;
  logic signed [31:0] s1_epl_q, s1_epr_q;
  logic [30:0]        s1_wl_q, s1_wr_q;
  logic signed [31:0] s1_ul_q, s1_ur_q, s1_el_q, s1_er_q;
  logic [30:0]        s1_pl_q, s1_pr_q, s1_rl_q, s1_rr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[0]) begin
      s1_prl_q <= $signed({1'b0, in_i.data.rho_left}) * in_i.data.vel_left;
      s1_prr_q <= $signed({1'b0, in_i.data.rho_right}) * in_i.data.vel_right;
      s1_phl_q <= in_i.data.humid_left * in_i.data.rho_left;
      s1_phr_q <= in_i.data.humid_right * in_i.data.rho_right;
      s1_epl_q <= sat32(64'(in_i.data.energy_left) + uext(in_i.data.pres_left));
      s1_epr_q <= sat32(64'(in_i.data.energy_right) + uext(in_i.data.pres_right));
      s1_wl_q  <= wave(in_i.data.vel_left, in_i.data.sound_left);
      s1_wr_q  <= wave(in_i.data.vel_right, in_i.data.sound_right);
      s1_ul_q  <= in_i.data.vel_left;
      s1_ur_q  <= in_i.data.vel_right;
      s1_el_q  <= in_i.data.energy_left;
      s1_er_q  <= in_i.data.energy_right;
      s1_pl_q  <= in_i.data.pres_left;
      s1_pr_q  <= in_i.data.pres_right;
      s1_rl_q  <= in_i.data.rho_left;
      s1_rr_q  <= in_i.data.rho_right;
    end
  end

  // Stage two: momenta and vapour densities, maximum wave speed.
  logic signed [31:0] s2_ml_q, s2_mr_q, s2_vl_q, s2_vr_q;
  logic [30:0]        s2_w_q;
  logic signed [31:0] s2_epl_q, s2_epr_q, s2_ul_q, s2_ur_q, s2_el_q, s2_er_q;
  logic [30:0]        s2_pl_q, s2_pr_q, s2_rl_q, s2_rr_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[1]) begin
      s2_ml_q  <= qmul_sat(s1_prl_q);
      s2_mr_q  <= qmul_sat(s1_prr_q);
      s2_vl_q  <= qmul_sat($signed(64'(s1_phl_q)));
      s2_vr_q  <= qmul_sat($signed(64'(s1_phr_q)));
      s2_w_q   <= (s1_wl_q > s1_wr_q) ? s1_wl_q : s1_wr_q;
      s2_epl_q <= s1_epl_q;
      s2_epr_q <= s1_epr_q;
      s2_ul_q  <= s1_ul_q;
      s2_ur_q  <= s1_ur_q;
      s2_el_q  <= s1_el_q;
      s2_er_q  <= s1_er_q;
      s2_pl_q  <= s1_pl_q;
      s2_pr_q  <= s1_pr_q;
      s2_rl_q  <= s1_rl_q;
      s2_rr_q  <= s1_rr_q;
    end
  end

  // Stage three: physical flux products and dissipation products.
  logic signed [31:0] s2_ws;
  logic signed [63:0] s3_pml_q, s3_pmr_q, s3_pel_q, s3_per_q, s3_pvl_q, s3_pvr_q;
  logic signed [63:0] s3_dm_q, s3_dmo_q, s3_de_q, s3_dv_q;
  logic signed [31:0] s3_ml_q, s3_mr_q;
  logic [30:0]        s3_pl_q, s3_pr_q, s3_w_q;

  assign s2_ws = $signed({1'b0, s2_w_q});

  always_ff @(posedge clk_i) begin
    if (ctrl.load[2]) begin
      s3_pml_q <= s2_ml_q * s2_ul_q;
      s3_pmr_q <= s2_mr_q * s2_ur_q;
      s3_pel_q <= s2_epl_q * s2_ul_q;
      s3_per_q <= s2_epr_q * s2_ur_q;
      s3_pvl_q <= s2_vl_q * s2_ul_q;
      s3_pvr_q <= s2_vr_q * s2_ur_q;
      s3_dm_q  <= sat32(uext(s2_rr_q) - uext(s2_rl_q)) * s2_ws;
      s3_dmo_q <= sat32(64'(s2_mr_q) - 64'(s2_ml_q)) * s2_ws;
      s3_de_q  <= sat32(64'(s2_er_q) - 64'(s2_el_q)) * s2_ws;
      s3_dv_q  <= sat32(64'(s2_vr_q) - 64'(s2_vl_q)) * s2_ws;
      s3_ml_q  <= s2_ml_q;
      s3_mr_q  <= s2_mr_q;
      s3_pl_q  <= s2_pl_q;
      s3_pr_q  <= s2_pr_q;
      s3_w_q   <= s2_w_q;
    end
  end

  // Stage four: physical fluxes and halved dissipation terms.
  logic signed [31:0] s4_ml_q, s4_mr_q, s4_mfl_q, s4_mfr_q;
  logic signed [31:0] s4_efl_q, s4_efr_q, s4_vfl_q, s4_vfr_q;
  logic signed [46:0] s4_dm_q, s4_dmo_q, s4_de_q, s4_dv_q;
  logic [30:0]        s4_w_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[3]) begin
      s4_ml_q  <= s3_ml_q;
      s4_mr_q  <= s3_mr_q;
      s4_mfl_q <= sat32(64'(qmul_sat(s3_pml_q)) + uext(s3_pl_q));
      s4_mfr_q <= sat32(64'(qmul_sat(s3_pmr_q)) + uext(s3_pr_q));
      s4_efl_q <= qmul_sat(s3_pel_q);
      s4_efr_q <= qmul_sat(s3_per_q);
      s4_vfl_q <= qmul_sat(s3_pvl_q);
      s4_vfr_q <= qmul_sat(s3_pvr_q);
      s4_dm_q  <= 47'(s3_dm_q >>> (Frac + 1));
      s4_dmo_q <= 47'(s3_dmo_q >>> (Frac + 1));
      s4_de_q  <= 47'(s3_de_q >>> (Frac + 1));
      s4_dv_q  <= 47'(s3_dv_q >>> (Frac + 1));
      s4_w_q   <= s3_w_q;
    end
  end

  // Stage five: average minus dissipation, into the output register.
  out_t s5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.load[4]) begin
      s5_q.mass_out     <= rusanov(s4_ml_q, s4_mr_q, s4_dm_q);
      s5_q.momentum_out <= rusanov(s4_mfl_q, s4_mfr_q, s4_dmo_q);
      s5_q.energy_out   <= rusanov(s4_efl_q, s4_efr_q, s4_de_q);
      s5_q.vapor_out    <= rusanov(s4_vfl_q, s4_vfr_q, s4_dv_q);
      s5_q.wave_speed   <= s4_w_q;
    end
  end

  assign out_o.data = s5_q;
endmodule

// ===== rtl/core/rif_checker.sv =====
module rif_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_i,
  input logic          out_valid_i,
  input logic          out_ready_i,
  input rif_pkg::out_t out_data_i
);
  import rif_pkg::*;

  localparam int unsigned CntW = $clog2(NStages + 1);

  logic [CntW-1:0] cnt_q, cnt_d;

  assign cnt_d = cnt_q + CntW'(in_valid_i & in_ready_i) - CntW'(out_valid_i & out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The pipeline never holds more transactions than it has stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(NStages))
    else $error("more transactions in flight than pipeline stages");

  // A result is only offered for a transaction that was accepted earlier.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cnt_q != '0))
    else $error("result offered with no transaction in flight");

  // With the output side taking results, the input side must be ready.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("input stalled although the output is draining");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result dropped or changed");

endmodule

bind rusanov_interface_flux_unit rif_checker u_rif_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

// ===== tb/tb_rusanov_interface_flux_unit.sv =====
`timescale 1ns / 100ps

module tb_rusanov_interface_flux_unit;
  import rif_pkg::*;

  localparam int unsigned NDirected     = 16;
  localparam int unsigned NRandom       = 1034;
  localparam int unsigned HoldAt        = 300;
  localparam int unsigned BurstLen      = 60;
  localparam int unsigned DrainAt       = 650;
  localparam int unsigned RxHoldCycles  = 150;
  localparam int unsigned WatchdogLimit = 1000;

  localparam logic [31:0] One = 32'h0001_0000;

  class flux_scoreboard;
    out_t        expected_flux_q[$];
    int unsigned n_cells;
    int unsigned n_checked;
    int unsigned n_errors;
    int unsigned n_wave_sat;

    function int unsigned pending();
      return expected_flux_q.size();
    endfunction

    function longint clip_q(longint v);
      if (v > 64'sd2147483647) begin
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint qprod(longint a, longint b);
      return clip_q((a * b) >>> 16);
    endfunction

    function longint qsum(longint a, longint b);
      return clip_q(a + b);
    endfunction

    function longint edge_speed(longint u, longint a);
      longint w;
      w = ((u < 0) ? -u : u) + a;
      return (w > 64'sd2147483647) ? 64'sd2147483647 : w;
    endfunction

    function longint lf_flux(longint fl, longint fr, longint ql, longint qr, longint w);
      longint avg;
      longint diss;
      avg  = (fl + fr) >>> 1;
      diss = (w * clip_q(qr - ql)) >>> 17;
      return clip_q(avg - diss);
    endfunction

    function out_t predict_flux(in_t c);
      longint rl, rr, ul, ur, pl, pr, el, er, hl, hr, al, ar;
      longint wl, wr, w, mom_l, mom_r, vap_l, vap_r;
      out_t   r;
      rl = longint'(c.rho_left);
      rr = longint'(c.rho_right);
      ul = longint'(c.vel_left);
      ur = longint'(c.vel_right);
      pl = longint'(c.pres_left);
      pr = longint'(c.pres_right);
      el = longint'(c.energy_left);
      er = longint'(c.energy_right);
      hl = longint'(c.humid_left);
      hr = longint'(c.humid_right);
      al = longint'(c.sound_left);
      ar = longint'(c.sound_right);
      wl = edge_speed(ul, al);
      wr = edge_speed(ur, ar);
      w  = (wl > wr) ? wl : wr;
      mom_l = qprod(rl, ul);
      mom_r = qprod(rr, ur);
      vap_l = qprod(hl, rl);
      vap_r = qprod(hr, rr);
      r.mass_out     = 32'(lf_flux(mom_l, mom_r, rl, rr, w));
      r.momentum_out = 32'(lf_flux(qsum(qprod(mom_l, ul), pl), qsum(qprod(mom_r, ur), pr),
                                   mom_l, mom_r, w));
      r.energy_out   = 32'(lf_flux(qprod(qsum(el, pl), ul), qprod(qsum(er, pr), ur),
                                   el, er, w));
      r.vapor_out    = 32'(lf_flux(qprod(vap_l, ul), qprod(vap_r, ur), vap_l, vap_r, w));
      r.wave_speed   = 31'(w);
      return r;
    endfunction

    function void note_cell(in_t c);
      out_t f;
      f = predict_flux(c);
      expected_flux_q.push_back(f);
      n_cells++;
      if (f.wave_speed == 31'h7FFF_FFFF) begin
        n_wave_sat++;
      end
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_flux(out_t got);
      out_t want;
      if (expected_flux_q.size() == 0) begin
        $error("flux result %h arrived with no transaction outstanding", got);
        n_errors++;
        return;
      end
      want = expected_flux_q.pop_front();
      n_checked++;
      compare_field("mass_out", longint'(want.mass_out), longint'(got.mass_out));
      compare_field("momentum_out", longint'(want.momentum_out), longint'(got.momentum_out));
      compare_field("energy_out", longint'(want.energy_out), longint'(got.energy_out));
      compare_field("vapor_out", longint'(want.vapor_out), longint'(got.vapor_out));
      compare_field("wave_speed", longint'(want.wave_speed), longint'(got.wave_speed));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rif_in_if  in_if ();
  rif_out_if out_if ();

  rusanov_interface_flux_unit i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  flux_scoreboard sb = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          rx_hold_req = 1'b0;
  int unsigned tx_burst = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_stall_cycles = 0;

  always #6 clk = ~clk;

  function automatic logic [31:0] rand_q(bit may_negate);
    logic [31:0] v;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      v = $urandom_range(0, 32'h0004_0000);
    end else if (sel < 12) begin
      v = $urandom_range(0, 32'h00FF_FFFF);
    end else if (sel < 17) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 5))
        0: v = 32'h0000_0000;
        1: v = 32'h0000_0001;
        2: v = 32'h7FFF_FFFF;
        3: v = 32'h8000_0000;
        4: v = 32'hFFFF_FFFF;
        default: v = One;
      endcase
    end
    if (may_negate && $urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  function automatic logic [16:0] rand_humid();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel < 12) begin
      return 17'($urandom_range(0, 65536));
    end else if (sel < 14) begin
      return 17'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? 17'h1_0000 : 17'h0_0000;
  endfunction

  function automatic in_t random_cell();
    in_t c;
    c.rho_left     = 31'(rand_q(1'b0));
    c.rho_right    = 31'(rand_q(1'b0));
    c.vel_left     = rand_q(1'b1);
    c.vel_right    = rand_q(1'b1);
    c.pres_left    = 31'(rand_q(1'b0));
    c.pres_right   = 31'(rand_q(1'b0));
    c.energy_left  = rand_q(1'b1);
    c.energy_right = rand_q(1'b1);
    c.humid_left   = rand_humid();
    c.humid_right  = rand_humid();
    c.sound_left   = 31'(rand_q(1'b0));
    c.sound_right  = 31'(rand_q(1'b0));
    return c;
  endfunction

  task automatic send_cell(input in_t c, input bit drain);
    int unsigned gap;
    gap = (tx_burst > 0 || !tx_idle_on) ? 0 : $urandom_range(0, 9);
    if (tx_burst > 0) begin
      tx_burst--;
    end
    if ($urandom_range(0, 29) == 0) begin
      tx_idle_on = !tx_idle_on;
    end
    @(negedge clk);
    if (gap > 0 || drain) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
      if (drain) begin
        do @(negedge clk); while (sb.pending() != 0);
      end
    end
    in_if.valid <= 1'b1;
    in_if.data  <= c;
    do @(posedge clk); while (!in_if.ready);
    sb.note_cell(c);
  endtask

  initial begin
    in_t c;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < NDirected; k++) begin
      c = '0;
      case (k)
        1: begin
          c = '1;
          c.vel_left     = 32'sh7FFF_FFFF;
          c.vel_right    = 32'sh7FFF_FFFF;
          c.energy_left  = 32'sh7FFF_FFFF;
          c.energy_right = 32'sh7FFF_FFFF;
        end
        2: begin
          c.vel_left  = 32'sh8000_0000;
          c.vel_right = 32'sh8000_0000;
          c.rho_left  = 31'(One);
          c.rho_right = 31'(One);
        end
        3: begin
          c.vel_left    = 32'sh8000_0000;
          c.sound_right = '1;
        end
        4: begin
          c.rho_left     = 31'(One);
          c.rho_right    = 31'(One);
          c.vel_left     = 32'sh0000_8000;
          c.vel_right    = 32'sh0000_8000;
          c.pres_left    = 31'(One);
          c.pres_right   = 31'(One);
          c.energy_left  = 32'sh0002_8000;
          c.energy_right = 32'sh0002_8000;
          c.humid_left   = 17'h0_8000;
          c.humid_right  = 17'h0_8000;
          c.sound_left   = 31'h0001_3333;
          c.sound_right  = 31'h0001_3333;
        end
        5: begin
          c.rho_left     = 31'(One);
          c.rho_right    = 31'h0000_2000;
          c.pres_left    = 31'(One);
          c.pres_right   = 31'h0000_199A;
          c.energy_left  = 32'sh0002_8000;
          c.energy_right = 32'sh0000_4000;
          c.humid_left   = 17'h0_4CCD;
          c.humid_right  = 17'h0_B333;
          c.sound_left   = 31'h0001_2EE0;
          c.sound_right  = 31'h0001_0EE8;
        end
        6: begin
          c.rho_left    = '1;
          c.rho_right   = '1;
          c.vel_left    = One;
          c.vel_right   = One;
          c.humid_left  = 17'h1_FFFF;
          c.humid_right = 17'h1_8000;
        end
        7: begin
          c.energy_left  = 32'sh8000_0000;
          c.energy_right = 32'sh8000_0000;
          c.vel_left     = 32'shFFFF_0000;
          c.vel_right    = 32'shFFFF_0000;
          c.rho_left     = 31'(One);
          c.rho_right    = 31'(One);
        end
        8: begin
          c.energy_left  = 32'sh7FFF_FFFF;
          c.pres_left    = '1;
          c.energy_right = 32'sh8000_0000;
          c.vel_left     = 32'sh0002_0000;
          c.vel_right    = 32'shFFFE_0000;
        end
        9: begin
          c.rho_left  = '1;
          c.rho_right = '1;
          c.vel_left  = 32'sh8000_0000;
          c.vel_right = 32'sh7FFF_FFFF;
        end
        10: begin
          c.rho_left  = 31'(One);
          c.rho_right = 31'(One);
          c.vel_left  = 32'shFFFF_FFFF;
          c.vel_right = 32'shFFFF_FFFF;
        end
        11: begin
          c.sound_left  = '1;
          c.sound_right = '1;
        end
        12: begin
          c.rho_left     = '1;
          c.pres_left    = '1;
          c.sound_left   = '1;
          c.humid_left   = 17'h1_FFFF;
          c.vel_left     = 32'sh7FFF_FFFF;
          c.energy_left  = 32'sh7FFF_FFFF;
          c.vel_right    = 32'sh8000_0000;
          c.energy_right = 32'sh8000_0000;
        end
        13: begin
          c.rho_right    = '1;
          c.pres_right   = '1;
          c.sound_right  = '1;
          c.humid_right  = 17'h1_FFFF;
          c.vel_right    = 32'sh7FFF_FFFF;
          c.energy_right = 32'sh7FFF_FFFF;
          c.vel_left     = 32'sh8000_0000;
          c.energy_left  = 32'sh8000_0000;
        end
        14: begin
          c.rho_left    = 31'h0003_0000;
          c.rho_right   = 31'h0003_0000;
          c.vel_left    = 32'sh0000_C000;
          c.vel_right   = 32'sh0000_C000;
          c.humid_left  = 17'h1_0000;
          c.sound_left  = 31'(One);
          c.sound_right = 31'(One);
        end
        15: begin
          c.rho_left     = 31'd1;
          c.rho_right    = 31'd1;
          c.vel_left     = -32'sd1;
          c.vel_right    = 32'sd1;
          c.pres_left    = 31'd1;
          c.pres_right   = 31'd1;
          c.energy_left  = 32'sd1;
          c.energy_right = -32'sd1;
          c.humid_left   = 17'd1;
          c.humid_right  = 17'd1;
          c.sound_left   = 31'd1;
          c.sound_right  = 31'd1;
        end
        default: c = '0;
      endcase
      send_cell(c, 1'b0);
    end

    for (int k = 0; k < NRandom; k++) begin
      // The output is held back while the input keeps streaming, so the pipeline fills.
      if (k == HoldAt) begin
        rx_hold_req = 1'b1;
        tx_burst    = BurstLen;
      end
      send_cell(random_cell(), k == DrainAt);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * NStages) @(posedge clk);

    $display("Covered %0d interface transactions (%0d directed), %0d with saturated wave speed,",
             sb.n_cells, NDirected, sb.n_wave_sat);
    $display("with %0d cycles of input stall; %0d flux results checked, %0d field mismatches.",
             n_stall_cycles, sb.n_checked, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("** rusanov_interface_flux_unit: PASSED **");
    end else begin
      $display("** rusanov_interface_flux_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 9) : 0;
      if ($urandom_range(0, 29) == 0) begin
        rx_idle_on = !rx_idle_on;
      end
      @(negedge clk);
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (RxHoldCycles) @(negedge clk);
        rx_hold_req = 1'b0;
      end else if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_flux(out_if.data);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (in_if.valid && !in_if.ready) begin
      n_stall_cycles++;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("Watchdog: no transaction for %0d cycles.", WatchdogLimit);
      $display("** rusanov_interface_flux_unit: FAILED **");
      $finish;
    end
  end

endmodule
